[rtl/pci_pkg.sv]
`default_nettype none

package pci_pkg;

  localparam int CFG_W           = 10;
  localparam int CHAN_W          = 6;
  localparam int CHARGE_W        = 30;
  localparam int OUT_IDX_W       = 10;
  localparam int START_W         = 11;
  localparam int DEF_MAX_SAMPLES = 1024;
  localparam int DEF_SAMPLE_BITS = 10;

  localparam logic [CFG_W-1:0]    PRETRIG_RESET = 10'd64;
  localparam logic [CHARGE_W-1:0] CHARGE_MAX    = {CHARGE_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_BASE,
    ST_LEFT,
    ST_RIGHT,
    ST_INTEG,
    ST_EMIT
  } state_t;

  // scan pass run by the datapath
  typedef enum logic [1:0] {
    PH_BASE,
    PH_LEFT,
    PH_RIGHT,
    PH_INTEG
  } phase_t;

  typedef struct packed {
    logic   load_en;
    logic   go;
    phase_t phase;
    logic   emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/pulse_charge_integrator_unit.sv]
// Evaluation passes run after the last sample is taken; during the scans one stored sample
//   is read per cycle from the single read port. A new waveform is taken only after the
//   result of the last one has been loaded into the result register.
// Reset: rst_n synchronous, active low; clears control, counters and the result valid,
//   loads pretrigger length 64. The sample store is not cleared.
`default_nettype none

module pulse_charge_integrator_unit #(
  parameter int MAX_SAMPLES = pci_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pci_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // sample input
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic [pci_pkg::CHAN_W-1:0]     in_channel,
  input  wire logic                           in_last_sample,
  // pretrigger length write
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [pci_pkg::CFG_W-1:0]      cfg_data,
  // result
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pci_pkg::CHARGE_W-1:0]        out_charge_scaled,
  output logic [pci_pkg::OUT_IDX_W-1:0]       out_peak_index,
  output logic [pci_pkg::START_W-1:0]         out_window_start,
  output logic [pci_pkg::OUT_IDX_W-1:0]       out_window_end,
  output logic [pci_pkg::CHAN_W-1:0]          out_channel_out
);
  import pci_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Samples are taken one per cycle while the controller sits in its load
  // state; the last word of a waveform starts the evaluation passes.
  assign in_stall  = !cmd.load_en;
  // Register write is always taken.
  assign cfg_ready = 1'b1;

  // Sequencer: baseline pass, walk down from the peak, walk up from the peak,
  // window integration, then hand off to the result register.
  pci_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Sample store, peak tracker, scan pipeline (read, multiply by length,
  // compare against the baseline sum) and result register.
  pci_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_valid          (in_valid),
    .in_sample         (in_sample),
    .in_channel        (in_channel),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_charge_scaled (out_charge_scaled),
    .out_peak_index    (out_peak_index),
    .out_window_start  (out_window_start),
    .out_window_end    (out_window_end),
    .out_channel_out   (out_channel_out)
  );

endmodule

`default_nettype wire

[rtl/pci_ctrl.sv]
`default_nettype none

module pci_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last_sample,
  input  wire pci_pkg::dp_stat_t stat,
  output pci_pkg::ctl_cmd_t      cmd
);
  import pci_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last_sample) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_BASE;
      ST_BASE: begin
        if (stat.done) state_nxt = ST_LEFT;
      end
      ST_LEFT: begin
        if (stat.done) state_nxt = ST_RIGHT;
      end
      ST_RIGHT: begin
        if (stat.done) state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        if (stat.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.out_busy) state_nxt = ST_LOAD;
      end
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.phase   = PH_BASE;
    cmd.load_en = (state_r == ST_LOAD);
    unique case (state_r)
      ST_LOAD: ;
      ST_PREP: begin
        cmd.go    = 1'b1;
        cmd.phase = PH_BASE;
      end
      ST_BASE: begin
        cmd.go    = stat.done;
        cmd.phase = PH_LEFT;
      end
      ST_LEFT: begin
        cmd.go    = stat.done;
        cmd.phase = PH_RIGHT;
      end
      ST_RIGHT: begin
        cmd.go    = stat.done;
        cmd.phase = PH_INTEG;
      end
      ST_INTEG: ;
      ST_EMIT: begin
        cmd.emit = !stat.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/pci_datapath.sv]
`default_nettype none

module pci_datapath #(
  parameter int MAX_SAMPLES = pci_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_BITS = pci_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pci_pkg::ctl_cmd_t              cmd,
  output pci_pkg::dp_stat_t                   stat,
  input  wire logic                           in_valid,
  input  wire logic [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic [pci_pkg::CHAN_W-1:0]     in_channel,
  input  wire logic                           cfg_valid,
  input  wire logic [pci_pkg::CFG_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pci_pkg::CHARGE_W-1:0]        out_charge_scaled,
  output logic [pci_pkg::OUT_IDX_W-1:0]       out_peak_index,
  output logic [pci_pkg::START_W-1:0]         out_window_start,
  output logic [pci_pkg::OUT_IDX_W-1:0]       out_window_end,
  output logic [pci_pkg::CHAN_W-1:0]          out_channel_out
);
  import pci_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = (CW > CFG_W) ? CW : CFG_W;
  localparam int PW = SAMPLE_BITS + CFG_W;

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

  logic [CFG_W-1:0]       cfg_p_r;
  logic [CFG_W-1:0]       p_r;
  logic [CW-1:0]          count_r;
  logic [SAMPLE_BITS-1:0] peak_val_r;
  logic [IW-1:0]          peak_pos_r;
  logic [CHAN_W-1:0]      chan_r;

  phase_t                 ph_r;
  logic                   run_r;
  logic                   down_r;
  logic [IW-1:0]          addr_r;
  logic [IW-1:0]          lim_r;

  logic                   v1_r, lst1_r;
  logic [IW-1:0]          idx1_r;
  logic [SAMPLE_BITS-1:0] rd_r;

  logic                   v2_r, lst2_r;
  logic [IW-1:0]          idx2_r;
  logic [SAMPLE_BITS-1:0] d2_r;
  logic [PW-1:0]          prod2_r;

  logic [PW-1:0]          sum_r;
  logic [SW-1:0]          start_r;
  logic [IW-1:0]          end_r;
  logic                   end_neg_r;
  logic [CHARGE_W-1:0]    charge_r;
  logic                   done_r;
  logic                   out_valid_r;

  logic                   accept, full, wr_en;
  logic [CFG_W-1:0]       p_go;
  logic [SW-1:0]          base_len;
  logic [CW-1:0]          cnt_m1;
  logic [IW-1:0]          go_first, go_lim;
  logic                   go_down, go_empty;
  logic                   low, hit, fin;
  logic [SW-1:0]          start_cand;
  logic [PW-1:0]          excess;
  logic [CHARGE_W:0]      charge_sum;

  assign accept = in_valid && cmd.load_en;
  assign full   = (count_r >= CW'(MAX_SAMPLES));
  assign wr_en  = accept && !full;
  assign p_go   = (cfg_p_r == '0) ? CFG_W'(1) : cfg_p_r;
  assign cnt_m1 = count_r - CW'(1);
  assign base_len = (SW'(count_r) < SW'(p_go)) ? SW'(count_r) : SW'(p_go);

  // pass setup, sampled on go
  always_comb begin
    go_first = '0;
    go_lim   = '0;
    go_down  = 1'b0;
    go_empty = 1'b0;
    unique case (cmd.phase)
      PH_BASE: begin
        go_lim = IW'(base_len - SW'(1));
      end
      PH_LEFT: begin
        go_first = peak_pos_r;
        go_lim   = IW'(1);
        go_down  = 1'b1;
        go_empty = (peak_pos_r == '0);
      end
      PH_RIGHT: begin
        go_first = peak_pos_r;
        go_lim   = cnt_m1[IW-1:0];
      end
      PH_INTEG: begin
        go_first = start_r[IW-1:0];
        go_lim   = end_r;
        go_empty = end_neg_r || (start_r > SW'(end_r));
      end
      default: ;
    endcase
  end

  assign low = (prod2_r < sum_r);
  assign hit = v2_r && low && (ph_r == PH_LEFT || ph_r == PH_RIGHT);
  assign fin = v2_r && (lst2_r || hit);

  assign start_cand = hit ? (SW'(idx2_r) + SW'(1)) : '0;
  assign excess     = prod2_r - sum_r;
  assign charge_sum = {1'b0, charge_r} + (CHARGE_W + 1)'(excess);

  // sample store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[IW-1:0]] <= in_sample;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_p_r <= PRETRIG_RESET;
    end else if (cfg_valid) begin
      cfg_p_r <= cfg_data;
    end
  end

  // capture side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      peak_val_r <= '0;
      peak_pos_r <= '0;
      chan_r     <= '0;
    end else if (cmd.emit) begin
      count_r    <= '0;
      peak_val_r <= '0;
      peak_pos_r <= '0;
    end else if (accept) begin
      if (count_r == '0) chan_r <= in_channel;
      if (!full) begin
        count_r <= count_r + CW'(1);
        if (in_sample > peak_val_r) begin
          peak_val_r <= in_sample;
          peak_pos_r <= count_r[IW-1:0];
        end
      end
    end
  end

  // scan pipeline: address, read data, product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_BASE;
    end else begin
      done_r <= (cmd.go && go_empty) || fin;
      if (cmd.go) begin
        ph_r   <= cmd.phase;
        run_r  <= !go_empty;
        v1_r   <= 1'b0;
        v2_r   <= 1'b0;
      end else if (hit) begin
        run_r  <= 1'b0;
        v1_r   <= 1'b0;
        v2_r   <= 1'b0;
      end else begin
        v1_r <= run_r;
        v2_r <= v1_r;
        if (run_r && addr_r == lim_r) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      addr_r <= go_first;
      lim_r  <= go_lim;
      down_r <= go_down;
    end else if (run_r && addr_r != lim_r) begin
      addr_r <= down_r ? addr_r - IW'(1) : addr_r + IW'(1);
    end
    idx1_r  <= addr_r;
    lst1_r  <= (addr_r == lim_r);
    idx2_r  <= idx1_r;
    lst2_r  <= lst1_r;
    d2_r    <= rd_r;
    prod2_r <= PW'(rd_r) * PW'(p_r);
  end

  // pass results
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.phase == PH_BASE) begin
      p_r   <= p_go;
      sum_r <= '0;
    end else if (v2_r && ph_r == PH_BASE) begin
      sum_r <= sum_r + PW'(d2_r);
    end
    if (cmd.go && cmd.phase == PH_INTEG) begin
      charge_r <= '0;
    end else if (v2_r && ph_r == PH_INTEG && prod2_r > sum_r) begin
      charge_r <= (charge_sum > (CHARGE_W + 1)'(CHARGE_MAX)) ? CHARGE_MAX
                                                             : charge_sum[CHARGE_W-1:0];
    end
    if (fin && ph_r == PH_LEFT) begin
      start_r <= (start_cand < SW'(p_r)) ? SW'(p_r) : start_cand;
    end else if (cmd.go && cmd.phase == PH_LEFT && go_empty) begin
      start_r <= SW'(p_r);
    end
    if (fin && ph_r == PH_RIGHT) begin
      if (hit) begin
        end_neg_r <= (idx2_r == '0);
        end_r     <= (idx2_r == '0) ? '0 : idx2_r - IW'(1);
      end else begin
        end_neg_r <= 1'b0;
        end_r     <= cnt_m1[IW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_charge_scaled <= charge_r;
      out_peak_index    <= OUT_IDX_W'(peak_pos_r);
      out_window_start  <= START_W'(start_r);
      out_window_end    <= OUT_IDX_W'(end_r);
      out_channel_out   <= chan_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.done     = done_r;
  assign stat.out_busy = out_valid_r && out_stall;

endmodule

`default_nettype wire

[rtl/pci_checker.sv]
`default_nettype none

module pci_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_last_sample,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [pci_pkg::CHARGE_W-1:0]   out_charge_scaled,
  input wire logic [pci_pkg::START_W-1:0]    out_window_start,
  input wire logic [pci_pkg::OUT_IDX_W-1:0]  out_window_end
);
  import pci_pkg::*;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_charge_scaled)
      && $stable(out_window_start) && $stable(out_window_end))
    else $error("result word changed while stalled");

  // evaluation follows the last sample, so input closes right away
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_sample |=> in_stall)
    else $error("input open after last sample");

  // start is clamped to the pretrigger length, at least one
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_window_start != '0)
    else $error("window start is zero");

  // empty window gives no charge
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_window_start > {1'b0, out_window_end}) |-> out_charge_scaled == '0)
    else $error("charge on empty window");

endmodule

bind pulse_charge_integrator_unit pci_checker u_pci_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_sample    (in_last_sample),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_charge_scaled (out_charge_scaled),
  .out_window_start  (out_window_start),
  .out_window_end    (out_window_end)
);

`default_nettype wire
